/* hdl/prc_pkg.sv */
// Shared types, constants and helpers for the percentage ratio block.
package prc_pkg;

    localparam int unsigned DataW = 8;
    localparam int unsigned CntW  = 3;
    localparam int unsigned StW   = 3;

    localparam logic [DataW-1:0] SatValue  = 8'd255;
    localparam logic [DataW-1:0] SatLimit  = 8'd155;
    localparam logic [DataW-1:0] WholeStep = 8'd100;
    localparam logic [DataW-1:0] HalfScale = 8'd128;

    localparam logic [CntW-1:0] LastDivStep  = 3'd7;
    localparam logic [CntW-1:0] LastFracStep = 3'd6;

    // sequencer codes
    localparam logic [StW-1:0] StIdle  = 3'd0;
    localparam logic [StW-1:0] StDiv   = 3'd1;
    localparam logic [StW-1:0] StNorm  = 3'd2;
    localparam logic [StW-1:0] StFrac  = 3'd3;
    localparam logic [StW-1:0] StScale = 3'd4;
    localparam logic [StW-1:0] StWhole = 3'd5;

    typedef struct packed {
        logic             ge;
        logic [DataW-1:0] diff;
    } t_sub_res;

    // binary weight of each fraction step
    function automatic logic [DataW-1:0] frac_weight(input logic [CntW-1:0] idx);
        logic [DataW-1:0] w;
        unique case (idx)
            3'd0:    w = 8'd100;
            3'd1:    w = 8'd50;
            3'd2:    w = 8'd25;
            3'd3:    w = 8'd12;
            3'd4:    w = 8'd6;
            3'd5:    w = 8'd3;
            3'd6:    w = 8'd1;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

endpackage

/* hdl/percent_ratio_u8.sv */
// Top level: sequencer and datapath of the approximate percentage unit.
// From request to strobe: a zero divisor goes straight to the whole-unit stage; an exact
// quotient skips the fraction and scaling stages. Otherwise the order is 8 restoring division
// steps, normalisation, 7 fraction steps, scaling, the whole-unit stage and the strobe.
// Throughput: one request at a time; busy drops as the strobe rises, so the next may follow.
// Reset (synchronous, active low) returns the sequencer to idle, drops the strobe.
module percent_ratio_u8 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [prc_pkg::DataW-1:0] i_dividend,
    input  logic [prc_pkg::DataW-1:0] i_divisor,
    output logic                      o_valid,
    output logic [prc_pkg::DataW-1:0] o_percent
);

    // control state
    logic [prc_pkg::StW-1:0]   r_state, n_state;
    logic                      r_valid, n_valid;

    // payload state
    logic [prc_pkg::DataW-1:0] r_rem,   n_rem;    // remainder, later the fraction numerator
    logic [prc_pkg::DataW-1:0] r_den,   n_den;    // divisor, normalised in place
    logic [prc_pkg::DataW-1:0] r_quo,   n_quo;    // dividend bits in, quotient bits out
    logic [prc_pkg::DataW-1:0] r_frac,  n_frac;   // fraction sum, then running answer
    logic [prc_pkg::CntW-1:0]  r_cnt,   n_cnt;    // step counter for division and fraction
    logic [prc_pkg::CntW-1:0]  r_lzn,   n_lzn;    // shifts applied to the remainder
    logic [prc_pkg::CntW-1:0]  r_lzd,   n_lzd;    // shifts applied to the divisor
    logic [prc_pkg::DataW-1:0] r_pct,   n_pct;

    logic                      w_accept;
    logic [prc_pkg::DataW:0]   w_sub_a;
    prc_pkg::t_sub_res         w_sub;
    logic [prc_pkg::DataW:0]   w_shifted;
    logic [prc_pkg::DataW-1:0] w_num;
    logic [prc_pkg::CntW-1:0]  w_dshift;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != prc_pkg::StIdle);
    assign o_valid   = r_valid;
    assign o_percent = r_pct;

    // Division brings down the next dividend bit; fraction steps compare the
    // normalised remainder directly.
    assign w_shifted = {r_rem, r_quo[prc_pkg::DataW-1]};
    assign w_sub_a   = (r_state == prc_pkg::StDiv) ? w_shifted : {1'b0, r_rem};
    assign w_dshift  = r_lzn - r_lzd;

    prc_sub u_sub (
        .i_a   (w_sub_a),
        .i_b   (r_den),
        .o_res (w_sub)
    );

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_rem   = r_rem;
        n_den   = r_den;
        n_quo   = r_quo;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        n_lzn   = r_lzn;
        n_lzd   = r_lzd;
        n_pct   = r_pct;
        w_num   = w_sub.ge ? w_sub.diff : r_rem;

        unique case (r_state)
            prc_pkg::StIdle: begin
                if (w_accept) begin
                    n_rem  = '0;
                    n_den  = i_divisor;
                    n_quo  = i_dividend;
                    n_frac = '0;
                    n_cnt  = '0;
                    n_lzn  = '0;
                    n_lzd  = '0;
                    if (i_divisor == '0) begin
                        // nothing to divide by: answer saturated, no whole units
                        n_frac  = prc_pkg::SatValue;
                        n_quo   = '0;
                        n_state = prc_pkg::StWhole;
                    end else begin
                        n_state = prc_pkg::StDiv;
                    end
                end
            end

            prc_pkg::StDiv: begin
                // restoring division, one quotient bit per cycle
                n_rem = w_sub.ge ? w_sub.diff : w_shifted[prc_pkg::DataW-1:0];
                n_quo = {r_quo[prc_pkg::DataW-2:0], w_sub.ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == prc_pkg::LastDivStep) begin
                    n_state = prc_pkg::StNorm;
                end
            end

            prc_pkg::StNorm: begin
                if (r_rem == '0) begin
                    // exact quotient: only whole units count
                    n_state = prc_pkg::StWhole;
                end else if (r_rem[prc_pkg::DataW-1] && r_den[prc_pkg::DataW-1]) begin
                    n_cnt   = '0;
                    n_state = prc_pkg::StFrac;
                end else begin
                    // advance both operands towards a set top bit together
                    if (!r_rem[prc_pkg::DataW-1]) begin
                        n_rem = {r_rem[prc_pkg::DataW-2:0], 1'b0};
                        n_lzn = r_lzn + 1'b1;
                    end
                    if (!r_den[prc_pkg::DataW-1]) begin
                        n_den = {r_den[prc_pkg::DataW-2:0], 1'b0};
                        n_lzd = r_lzd + 1'b1;
                    end
                end
            end

            prc_pkg::StFrac: begin
                if (w_sub.ge) begin
                    n_frac = r_frac + prc_pkg::frac_weight(r_cnt);
                end
                // keep the remainder large: shift it up, or else halve the divisor
                if (w_num < prc_pkg::HalfScale) begin
                    n_rem = {w_num[prc_pkg::DataW-2:0], 1'b0};
                end else begin
                    n_rem = w_num;
                    n_den = {1'b0, r_den[prc_pkg::DataW-1:1]};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == prc_pkg::LastFracStep) begin
                    n_state = prc_pkg::StScale;
                end
            end

            prc_pkg::StScale: begin
                // undo the normalisation difference
                n_frac  = r_frac >> w_dshift;
                n_state = prc_pkg::StWhole;
            end

            prc_pkg::StWhole: begin
                // add 100 per whole unit; saturate before the sum can pass 255
                if (r_quo == '0) begin
                    n_pct   = r_frac;
                    n_valid = 1'b1;
                    n_state = prc_pkg::StIdle;
                end else if (r_frac > prc_pkg::SatLimit) begin
                    n_pct   = prc_pkg::SatValue;
                    n_valid = 1'b1;
                    n_state = prc_pkg::StIdle;
                end else begin
                    n_frac = r_frac + prc_pkg::WholeStep;
                    n_quo  = r_quo - 1'b1;
                end
            end

            default: begin
                n_state = prc_pkg::StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prc_pkg::StIdle;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quo  <= n_quo;
        r_frac <= n_frac;
        r_cnt  <= n_cnt;
        r_lzn  <= n_lzn;
        r_lzd  <= n_lzd;
        r_pct  <= n_pct;
    end

`ifndef ASSERT_OFF
    // an accepted request always holds the unit busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("request accepted but unit not busy");

    // the strobe comes only once the sequencer has returned to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    // a zero divisor answers 255 right after the whole-unit state
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_divisor == '0) |=> ##1 (o_valid && o_percent == prc_pkg::SatValue))
        else $error("zero divisor did not saturate");

    // the normalisation shift difference never goes negative
    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prc_pkg::StScale) |-> (r_lzn >= r_lzd))
        else $error("divisor shifted more than remainder");
`endif

endmodule

/* hdl/prc_sub.sv */
// Shared compare-and-subtract unit used by the division and fraction steps.
module prc_sub (
    input  logic [prc_pkg::DataW:0]   i_a,
    input  logic [prc_pkg::DataW-1:0] i_b,
    output prc_pkg::t_sub_res         o_res
);

    logic [prc_pkg::DataW+1:0] w_diff;

    assign w_diff     = {1'b0, i_a} - {2'b00, i_b};
    assign o_res.ge   = ~w_diff[prc_pkg::DataW+1];
    assign o_res.diff = w_diff[prc_pkg::DataW-1:0];

endmodule

/* tb/sv/percent_ratio_u8_checker.sv */
// Checker for the percentage unit: predicts each request's result and compares it.
module percent_ratio_u8_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [prc_pkg::DataW-1:0] i_dividend,
    input  logic [prc_pkg::DataW-1:0] i_divisor,
    input  logic                      o_valid,
    input  logic [prc_pkg::DataW-1:0] o_percent,
    output int unsigned               o_errors,
    output int unsigned               o_pending,
    output int unsigned               o_checked,
    output int unsigned               o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    import prc_pkg::*;

    localparam logic [DataW-1:0] FracWeight [7] = '{8'd100, 8'd50, 8'd25, 8'd12,
                                                     8'd6, 8'd3, 8'd1};

    logic [DataW-1:0] percent_q [$];

    function automatic logic [DataW-1:0] expected_percent(input logic [DataW-1:0] num_in,
                                                          input logic [DataW-1:0] den_in);
        logic [DataW-1:0] num;
        logic [DataW-1:0] den;
        logic [DataW-1:0] whole;
        logic [DataW-1:0] frac;
        int               num_shift;
        int               den_shift;
        num       = num_in;
        den       = den_in;
        whole     = '0;
        frac      = '0;
        num_shift = 0;
        den_shift = 0;
        if (den == '0) begin
            return SatValue;
        end
        while (num >= den) begin
            num   = num - den;
            whole = whole + 1'b1;
        end
        if (num != '0) begin
            // normalise both so bit 7 is set
            while (!num[DataW-1]) begin
                num       = num << 1;
                num_shift = num_shift + 1;
            end
            while (!den[DataW-1]) begin
                den       = den << 1;
                den_shift = den_shift + 1;
            end
            for (int i = 0; i < 7; i++) begin
                if (num >= den) begin
                    num  = num - den;
                    frac = frac + FracWeight[i];
                end
                if (num < HalfScale) begin
                    num = num << 1;
                end else begin
                    den = den >> 1;
                end
            end
            frac = frac >> ((num_shift - den_shift) & 7);
        end
        for (int k = 0; k < whole; k++) begin
            if (frac > SatLimit) begin
                return SatValue;
            end
            frac = frac + WholeStep;
        end
        return frac;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_errors = o_errors + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors    = 0;
            o_pending   = 0;
            o_checked   = 0;
            o_saturated = 0;
            percent_q.delete();
        end else begin
            // results first, so a request taken at the strobe edge queues behind
            if (o_valid) begin
                if (percent_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result percent=%0d", o_percent));
                end else begin
                    logic [DataW-1:0] want;
                    want = percent_q.pop_front();
                    if (o_percent !== want) begin
                        report_mismatch($sformatf("percent=%0d, want %0d", o_percent, want));
                    end
                    if (want == SatValue) begin
                        o_saturated = o_saturated + 1;
                    end
                    o_checked = o_checked + 1;
                end
            end
            if (start && !busy) begin
                percent_q.push_back(expected_percent(i_dividend, i_divisor));
            end
            o_pending = percent_q.size();
        end
    end

endmodule

/* tb/sv/percent_ratio_u8_tb.sv */
// Testbench top for the percentage unit: clock, reset, request stimulus and verdict.
module percent_ratio_u8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prc_pkg::*;

    localparam int unsigned RandomRequests = 1700;
    localparam int unsigned DrainCycles    = 40;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    logic [DataW-1:0] i_dividend = '0;
    logic [DataW-1:0] i_divisor  = '0;
    logic             o_valid;
    logic [DataW-1:0] o_percent;

    int unsigned errors;
    int unsigned pending;
    int unsigned checked;
    int unsigned saturated;
    int unsigned sent;

    percent_ratio_u8 uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .o_percent  (o_percent)
    );

    percent_ratio_u8_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_valid     (o_valid),
        .o_percent   (o_percent),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_saturated (saturated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #10ms;
        $display("status: fail");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Present one request and hold it until the unit takes it. With no gap,
    // leave start high so the caller can chain the next request in the same step.
    task automatic send_request(input logic [DataW-1:0] dividend,
                                input logic [DataW-1:0] divisor,
                                input int unsigned gap);
        start      <= 1'b1;
        i_dividend <= dividend;
        i_divisor  <= divisor;
        // busy only moves at a rising edge, so look at it mid-cycle
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sent = sent + 1;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Draw operands: zero divisors, tiny divisors that can saturate, ratios close to
    // one, pure fractions, and fully random pairs.
    task automatic pick_operands(output logic [DataW-1:0] dividend,
                                 output logic [DataW-1:0] divisor);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            divisor  = '0;
            dividend = DataW'($urandom_range(0, 255));
        end else if (r < 25) begin
            divisor  = DataW'($urandom_range(1, 4));
            dividend = DataW'($urandom_range(0, 255));
        end else if (r < 45) begin
            divisor  = DataW'($urandom_range(1, 255));
            dividend = divisor + DataW'($urandom_range(0, 6)) - 8'd3;
        end else if (r < 60) begin
            divisor  = DataW'($urandom_range(2, 255));
            dividend = DataW'($urandom_range(1, divisor - 1));
        end else begin
            divisor  = DataW'($urandom_range(0, 255));
            dividend = DataW'($urandom_range(0, 255));
        end
    endtask

    initial begin
        logic [DataW-1:0] dividend;
        logic [DataW-1:0] divisor;
        logic             quiet;
        sent  = 0;
        quiet = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero divisor, field extremes, exact quotients, pure fractions,
        // early-exhausted remainders and the saturation boundary.
        send_request(8'd0,   8'd0,   0);
        send_request(8'd255, 8'd0,   1);
        send_request(8'd0,   8'd255, 0);
        send_request(8'd255, 8'd255, 2);
        send_request(8'd255, 8'd1,   0);
        send_request(8'd1,   8'd255, 0);
        send_request(8'd1,   8'd1,   3);
        send_request(8'd2,   8'd1,   0);
        send_request(8'd3,   8'd1,   0);
        send_request(8'd50,  8'd100, 0);
        send_request(8'd200, 8'd100, 1);
        send_request(8'd199, 8'd100, 0);
        send_request(8'd255, 8'd100, 0);
        send_request(8'd100, 8'd99,  5);
        send_request(8'd127, 8'd128, 0);
        send_request(8'd128, 8'd255, 0);
        send_request(8'd254, 8'd255, 0);
        send_request(8'd1,   8'd2,   0);
        send_request(8'd1,   8'd3,   1);
        send_request(8'd2,   8'd3,   0);
        send_request(8'd3,   8'd255, 0);
        send_request(8'd1,   8'd128, 0);
        send_request(8'd170, 8'd85,  0);
        send_request(8'd171, 8'd85,  0);

        for (int unsigned n = 0; n < RandomRequests; n++) begin
            // switch between back-to-back stretches and gappy ones
            if (n % 200 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            pick_operands(dividend, divisor);
            send_request(dividend, divisor, quiet ? 0 : gap_length());
            // hold off once until the unit has drained completely
            if (n == RandomRequests / 2) begin
                start <= 1'b0;
                @(negedge i_clk);
                while (pending != 0) @(negedge i_clk);
                @(posedge i_clk);
            end
        end
        start <= 1'b0;

        // drain outstanding results, then idle for DrainCycles before the verdict
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("summary: %0d requests sent, %0d results checked, %0d saturated",
                 sent, checked, saturated);
        $display("summary: zero divisors, exact quotients, fractions and overflow exercised");
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/prc_pkg.sv
hdl/prc_sub.sv
hdl/percent_ratio_u8.sv
tb/sv/percent_ratio_u8_checker.sv
tb/sv/percent_ratio_u8_tb.sv
